[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle rule");

`endif

[rtl/ctes_pkg.sv]
// shared widths, constants and month table for the calendar to epoch converter
`timescale 1ns / 1ps

package ctes_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int OFS_W   = 18;
    localparam int SECS_W  = 39;
    localparam int DOY_W   = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_UTC_OFFSET = '0;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 14'd1970;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DOY_W-1:0]   DOY_MAX    = 9'd365;

    // year/4 fits in 12 bits; x/25 == (x * 2622) >> 16 for all such x
    localparam int QUART_W     = YEAR_W - 2;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = 2 * QUART_W;
    localparam int CENT_W      = 8;
    localparam logic [QUART_W-1:0] RECIP_25 = 12'd2622;
    localparam logic [QUART_W-1:0] CENT_DIV = 12'd25;

    // leap days through 1969 plus the one-based day correction
    localparam int DAYS_W = 25;
    localparam logic signed [DAYS_W-1:0] DAYS_BIAS = 25'sd478;

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        begin
            case (m)
                4'd1:    d = 9'd0;
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                4'd12:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

[rtl/calendar_to_epoch_seconds_unit.sv]
// calendar date and time to epoch seconds, five-stage pipeline
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (utc offset register)
//  input    | in_valid / in_stall  | year, month, day, hour, minute, second
//  output   | out_valid/out_stall  | epoch_seconds, day_of_year, valid_res
//
//  one beat per cycle sustained while out_stall is low
//  stages: reciprocal multiply, leap/year terms, day sum, day*86400 multiply, final add
//  each stage holds its beat while the stage after it is full and stalled
//  rst_n clears the stage valid bits and the offset register to zero
`timescale 1ns / 1ps

module calendar_to_epoch_seconds_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctes_pkg::PADDR_W-1:0]        paddr,
    input  logic [ctes_pkg::PDATA_W-1:0]        pwdata,
    output logic [ctes_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ctes_pkg::YEAR_W-1:0]         year,
    input  logic [ctes_pkg::MONTH_W-1:0]        month,
    input  logic [ctes_pkg::DAY_W-1:0]          day,
    input  logic [ctes_pkg::HOUR_W-1:0]         hour,
    input  logic [ctes_pkg::MIN_W-1:0]          minute,
    input  logic [ctes_pkg::SEC_W-1:0]          second,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ctes_pkg::SECS_W-1:0]  epoch_seconds,
    output logic [ctes_pkg::DOY_W-1:0]          day_of_year,
    output logic                                valid_res
);

    import ctes_pkg::*;

    localparam int YD_W  = 23;
    localparam int TOD_W = 17;
    localparam int TOS_W = 19;
    localparam int MUL_W = 40;

    typedef struct packed {
        logic                ok;
        logic [QUART_W-1:0]  m1;
        logic [QUART_W-1:0]  m2;
        logic [PROD_W-1:0]   p1;
        logic [PROD_W-1:0]   p2;
        logic                y4;
        logic                late;
        logic [YEAR_W-1:0]   dy;
        logic [DOY_W-1:0]    prior;
        logic [DOY_W-1:0]    doy;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
    } s1_t;

    typedef struct packed {
        logic                     ok;
        logic [YD_W-1:0]          yd;
        logic [QUART_W-1:0]       lp;
        logic                     add_leap;
        logic [DOY_W-1:0]         prior;
        logic [DOY_W-1:0]         doy;
        logic [DAY_W-1:0]         day;
        logic signed [TOS_W-1:0]  tod;
    } s2_t;

    typedef struct packed {
        logic                      ok;
        logic signed [DAYS_W-1:0]  days;
        logic signed [TOS_W-1:0]   tod;
        logic [DOY_W-1:0]          doy;
    } s3_t;

    typedef struct packed {
        logic                     ok;
        logic signed [MUL_W-1:0]  prod;
        logic signed [TOS_W-1:0]  tod;
        logic [DOY_W-1:0]         doy;
    } s4_t;

    // configuration register
    logic signed [OFS_W-1:0] ofs_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_UTC_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg <= '0;
        end
        else if (cfg_wr)
        begin
            ofs_reg <= pwdata[OFS_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == REG_UTC_OFFSET)
        begin
            prdata = {{(PDATA_W-OFS_W){ofs_reg[OFS_W-1]}}, ofs_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // stage valid bits and ready chain
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !s5_v_reg || !out_stall;
    assign rdy4     = !s4_v_reg || rdy5;
    assign rdy3     = !s3_v_reg || rdy4;
    assign rdy2     = !s2_v_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_v_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (rdy3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (rdy4)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (rdy5)
            begin
                s5_v_reg <= s4_v_reg;
            end
        end
    end

    // stage 1: range check, year/4 terms, reciprocal multiplies
    s1_t              s1_next, s1_reg;
    logic [YEAR_W-1:0] ym1;

    always_comb
    begin
        ym1            = year - 14'd1;
        s1_next.ok     = (month >= MONTH_JAN) && (month <= MONTH_DEC) && (year >= EPOCH_YEAR);
        s1_next.m1     = ym1[YEAR_W-1:2];
        s1_next.m2     = year[YEAR_W-1:2];
        s1_next.p1     = {{QUART_W{1'b0}}, s1_next.m1} * {{QUART_W{1'b0}}, RECIP_25};
        s1_next.p2     = {{QUART_W{1'b0}}, s1_next.m2} * {{QUART_W{1'b0}}, RECIP_25};
        s1_next.y4     = (year[1:0] == 2'd0);
        s1_next.late   = (month > MONTH_FEB);
        s1_next.dy     = year - EPOCH_YEAR;
        s1_next.prior  = days_before(month);
        s1_next.doy    = s1_next.prior + {{(DOY_W-DAY_W){1'b0}}, day};
        s1_next.day    = day;
        s1_next.hour   = hour;
        s1_next.minute = minute;
        s1_next.second = second;
    end

    // stage 2: leap count, leap flag, 365 * years, time of day less offset
    s2_t                s2_next, s2_reg;
    logic [CENT_W-1:0]  q1, q2;
    logic [QUART_W-1:0] r2;
    logic [TOD_W-1:0]   tod_u;

    always_comb
    begin
        q1 = s1_reg.p1[RECIP_SHIFT +: CENT_W];
        q2 = s1_reg.p2[RECIP_SHIFT +: CENT_W];
        r2 = s1_reg.m2 - QUART_W'({{(QUART_W-CENT_W){1'b0}}, q2} * CENT_DIV);
        s2_next.ok       = s1_reg.ok;
        s2_next.lp       = s1_reg.m1 - {{(QUART_W-CENT_W){1'b0}}, q1}
                         + {{(QUART_W-CENT_W+2){1'b0}}, q1[CENT_W-1:2]};
        s2_next.add_leap = s1_reg.late && s1_reg.y4 && ((r2 != '0) || (q2[1:0] == 2'd0));
        s2_next.yd       = {{(YD_W-YEAR_W){1'b0}}, s1_reg.dy} * 23'd365;
        s2_next.prior    = s1_reg.prior;
        s2_next.doy      = s1_reg.doy;
        s2_next.day      = s1_reg.day;
        tod_u            = TOD_W'({{(TOD_W-HOUR_W){1'b0}}, s1_reg.hour} * 17'd3600)
                         + TOD_W'({{(TOD_W-MIN_W){1'b0}}, s1_reg.minute} * 17'd60)
                         + {{(TOD_W-SEC_W){1'b0}}, s1_reg.second};
        s2_next.tod      = $signed({2'b00, tod_u}) - $signed({ofs_reg[OFS_W-1], ofs_reg});
    end

    // stage 3: whole days since the epoch
    s3_t s3_next, s3_reg;

    always_comb
    begin
        s3_next.ok   = s2_reg.ok;
        s3_next.days = $signed({{(DAYS_W-YD_W){1'b0}}, s2_reg.yd})
                     + $signed({{(DAYS_W-QUART_W){1'b0}}, s2_reg.lp})
                     + $signed({{(DAYS_W-DOY_W){1'b0}}, s2_reg.prior})
                     + $signed({{(DAYS_W-1){1'b0}}, s2_reg.add_leap})
                     + $signed({{(DAYS_W-DAY_W){1'b0}}, s2_reg.day})
                     - DAYS_BIAS;
        s3_next.tod  = s2_reg.tod;
        s3_next.doy  = s2_reg.doy;
    end

    // stage 4: days to seconds
    s4_t s4_next, s4_reg;

    always_comb
    begin
        s4_next.ok   = s3_reg.ok;
        s4_next.prod = $signed({{(MUL_W-DAYS_W){s3_reg.days[DAYS_W-1]}}, s3_reg.days})
                     * 40'sd86400;
        s4_next.tod  = s3_reg.tod;
        s4_next.doy  = s3_reg.doy;
    end

    // stage 5: final sum into the output register
    logic signed [MUL_W-1:0] secs_full;
    logic signed [SECS_W-1:0] epoch_next, epoch_reg;
    logic [DOY_W-1:0]         doy_next, doy_reg;
    logic                     vres_reg;

    always_comb
    begin
        secs_full = s4_reg.prod + $signed({{(MUL_W-TOS_W){s4_reg.tod[TOS_W-1]}}, s4_reg.tod});
        if (s4_reg.ok)
        begin
            epoch_next = secs_full[SECS_W-1:0];
            doy_next   = s4_reg.doy;
        end
        else
        begin
            epoch_next = '0;
            doy_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4)
        begin
            s4_reg <= s4_next;
        end
        if (rdy5)
        begin
            epoch_reg <= epoch_next;
            doy_reg   <= doy_next;
            vres_reg  <= s4_reg.ok;
        end
    end

    assign out_valid     = s5_v_reg;
    assign epoch_seconds = epoch_reg;
    assign day_of_year   = doy_reg;
    assign valid_res     = vres_reg;

endmodule

[rtl/ctes_checker.sv]
// port-level checks for the calendar to epoch converter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctes_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [ctes_pkg::SECS_W-1:0]  epoch_seconds,
    input logic [ctes_pkg::DOY_W-1:0]          day_of_year,
    input logic                                valid_res
);

    import ctes_pkg::*;

    logic in_wait;

    assign in_wait = in_valid && in_stall;

    // the input side only waits while a finished beat is held at the output
    `ASSERT_SAME(a_stall_needs_full_out, in_wait, out_valid && out_stall)

    // a held output beat stays put
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(epoch_seconds) && $stable(day_of_year) && $stable(valid_res))

    // rejected dates carry zero fields
    `ASSERT_SAME(a_invalid_zero, out_valid && !valid_res, (epoch_seconds == '0) && (day_of_year == '0))

    // day of year never runs past the table end plus the last day
    `ASSERT_SAME(a_doy_range, out_valid, day_of_year <= DOY_MAX)

endmodule

bind calendar_to_epoch_seconds_unit ctes_checker u_ctes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds),
    .day_of_year   (day_of_year),
    .valid_res     (valid_res)
);

[tb/sv/calendar_to_epoch_seconds_unit_tb.sv]
// self-checking testbench for the calendar to epoch seconds converter
`timescale 1ns / 1ps

module calendar_to_epoch_seconds_unit_tb;

    import ctes_pkg::*;

    localparam int STALE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } date_t;

    typedef struct packed {
        logic [SECS_W-1:0] secs;
        logic [DOY_W-1:0]  doy;
        logic              ok;
    } stamp_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_stall;
    logic [YEAR_W-1:0]         year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic [HOUR_W-1:0]         hour;
    logic [MIN_W-1:0]          minute;
    logic [SEC_W-1:0]          second;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [SECS_W-1:0]  epoch_seconds;
    logic [DOY_W-1:0]          day_of_year;
    logic                      valid_res;

    logic signed [OFS_W-1:0] zone_offset;
    stamp_t                  pending_stamps[$];
    bit                      steady;
    int                      hold_left;
    int                      stale_cycles;
    int                      mismatches;
    int                      checked_count;
    int                      invalid_count;
    int                      zones_written;
    int                      input_stalls;

    calendar_to_epoch_seconds_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_seconds (epoch_seconds),
        .day_of_year   (day_of_year),
        .valid_res     (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // gregorian calendar arithmetic

    function automatic bit is_leap(input longint y);
        if (y % 400 == 0)
            return 1'b1;
        if (y % 100 == 0)
            return 1'b0;
        return (y % 4 == 0);
    endfunction

    function automatic longint leaps_upto(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int month_length(input int m);
        case (m)
            2:            return 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic stamp_t convert_date(input date_t dt);
        stamp_t r;
        longint yr;
        longint days;
        longint secs;
        int     prior;
        r = '0;
        if (dt.month < MONTH_JAN || dt.month > MONTH_DEC || dt.year < EPOCH_YEAR)
            return r;
        prior = 0;
        for (int m = 1; m < int'(dt.month); m++)
            prior += month_length(m);
        yr = longint'(dt.year);
        days = 365 * (yr - longint'(EPOCH_YEAR)) + leaps_upto(yr - 1)
             - leaps_upto(longint'(EPOCH_YEAR) - 1);
        days += prior;
        if (dt.month > MONTH_FEB && is_leap(yr))
            days += 1;
        days += longint'(dt.day) - 1;
        secs = ((days * 24 + longint'(dt.hour)) * 60 + longint'(dt.minute)) * 60
             + longint'(dt.second);
        secs -= longint'(zone_offset);
        r.secs = secs[SECS_W-1:0];
        r.doy  = DOY_W'(prior + int'(dt.day));
        r.ok   = 1'b1;
        return r;
    endfunction

    function automatic date_t mk(input int y, input int m, input int d,
                                 input int h, input int mi, input int s);
        date_t dt;
        dt.year   = YEAR_W'(y);
        dt.month  = MONTH_W'(m);
        dt.day    = DAY_W'(d);
        dt.hour   = HOUR_W'(h);
        dt.minute = MIN_W'(mi);
        dt.second = SEC_W'(s);
        return dt;
    endfunction

    function automatic date_t random_date();
        date_t dt;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            dt = mk($urandom_range(1970, 9999), $urandom_range(1, 12),
                    $urandom_range(1, 31), $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 61));
            if ($urandom_range(0, 3) == 0)
            begin
                dt.year  = YEAR_W'(4 * $urandom_range(493, 2499));
                dt.month = MONTH_W'($urandom_range(2, 3));
            end
        end
        else if (pick < 82)
        begin
            dt = mk($urandom, $urandom_range(13, 16), $urandom, $urandom,
                    $urandom, $urandom);
            if ($urandom_range(0, 1) == 0)
                dt = mk($urandom_range(0, 1969), $urandom_range(1, 12),
                        $urandom_range(1, 31), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
        end
        else
        begin
            dt = date_t'({$urandom, $urandom});
        end
        return dt;
    endfunction

    // scoreboard and idle watch

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        stamp_t want;
        date_t  dt;
        if (rst_n)
        begin
            stale_cycles++;
            if (out_valid && !out_stall)
            begin
                stale_cycles = 0;
                if (pending_stamps.size() == 0)
                begin
                    report_mismatch("unexpected result beat", longint'(epoch_seconds), 0);
                end
                else
                begin
                    want = pending_stamps.pop_front();
                    checked_count++;
                    if (!want.ok)
                        invalid_count++;
                    if (epoch_seconds !== want.secs)
                        report_mismatch("epoch_seconds", longint'(epoch_seconds),
                                        longint'(want.secs));
                    if (day_of_year !== want.doy)
                        report_mismatch("day_of_year", longint'(day_of_year),
                                        longint'(want.doy));
                    if (valid_res !== want.ok)
                        report_mismatch("valid_res", longint'(valid_res), longint'(want.ok));
                end
            end
            if (in_valid)
            begin
                if (in_stall)
                begin
                    input_stalls++;
                end
                else
                begin
                    stale_cycles = 0;
                    dt = '{year, month, day, hour, minute, second};
                    pending_stamps.push_back(convert_date(dt));
                end
            end
        end
    end

    initial
    begin
        stale_cycles = 0;
        @(posedge rst_n);
        while (stale_cycles < STALE_LIMIT)
            @(posedge clk);
        $display("no beat accepted for %0d cycles", STALE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, plus a counted hold when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(0, 99) < 25);
            end
        end
    end

    // shared drive tasks

    task automatic send_beat(input date_t dt);
        int gap;
        if (!steady && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        year     <= dt.year;
        month    <= dt.month;
        day      <= dt.day;
        hour     <= dt.hour;
        minute   <= dt.minute;
        second   <= dt.second;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [OFS_W-1:0] ofs);
        drain_results();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_UTC_OFFSET, 2'b00};
        pwdata  <= {{(PDATA_W - OFS_W){ofs[OFS_W-1]}}, ofs};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        zone_offset = ofs;
        zones_written++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_zone(input logic signed [OFS_W-1:0] ofs, input int count);
        write_offset(ofs);
        repeat (count) send_beat(random_date());
    endtask

    // tests

    task automatic test_directed();
        send_beat(mk(1970, 1, 1, 0, 0, 0));
        send_beat(mk(1969, 12, 31, 23, 59, 59));
        send_beat(mk(0, 1, 1, 0, 0, 0));
        send_beat(mk(2000, 2, 29, 12, 0, 0));
        send_beat(mk(2000, 3, 1, 0, 0, 0));
        send_beat(mk(2100, 3, 1, 0, 0, 0));
        send_beat(mk(2400, 3, 1, 0, 0, 0));
        send_beat(mk(2023, 3, 1, 0, 0, 0));
        send_beat(mk(2024, 0, 10, 1, 2, 3));
        send_beat(mk(2024, 13, 10, 1, 2, 3));
        send_beat(mk(2024, 15, 10, 1, 2, 3));
        send_beat(mk(9999, 12, 31, 23, 59, 59));
        send_beat(mk(16383, 12, 31, 31, 63, 63));
        send_beat(mk(16383, 15, 31, 31, 63, 63));
        send_beat(mk(2024, 1, 0, 0, 0, 0));
        send_beat(mk(1970, 12, 0, 0, 0, 0));
        send_beat(mk(2016, 12, 31, 23, 59, 60));
        send_beat(mk(2016, 12, 31, 23, 59, 61));
        send_beat(mk(1970, 1, 31, 31, 63, 63));
        for (int m = 1; m <= 12; m++)
            send_beat(mk(2023, m, 15, 6, 30, 0));
    endtask

    task automatic test_offset_extremes();
        run_zone(-18'sd86400, 30);
        run_zone(18'sd86400, 30);
        run_zone(18'h20000, 30);
        run_zone(18'h1FFFF, 30);
        run_zone(-18'sd3600, 25);
        run_zone(OFS_W'($urandom), 25);
        run_zone('0, 10);
    endtask

    task automatic test_backpressure();
        drain_results();
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        steady = 1'b1;
        repeat (40) send_beat(random_date());
        steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random_mix();
        write_offset(OFS_W'($urandom_range(0, 172800)) - 18'sd86400);
        for (int i = 0; i < 1500; i++)
        begin
            steady = (i >= 400 && i < 700);
            send_beat(random_date());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        year     = '0;
        month    = '0;
        day      = '0;
        hour     = '0;
        minute   = '0;
        second   = '0;
        out_stall = 1'b0;
        steady   = 1'b0;
        hold_left = 0;
        zone_offset = '0;
        mismatches = 0;
        checked_count = 0;
        invalid_count = 0;
        zones_written = 0;
        input_stalls = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_offset_extremes();
        test_backpressure();
        test_random_mix();

        drain_results();
        repeat (12) @(posedge clk);
        $display("checked %0d conversions (%0d invalid dates) across %0d offset writes",
                 checked_count, invalid_count, zones_written);
        $display("leap rules, day zero, leap seconds and field maxima covered; %0d %s",
                 input_stalls, "input stall cycles seen");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
